// ===== rtl/bpsc_pkg.sv =====
// Shared types and constants for the barometer sequence/compensation block.
// No dependencies; imported by bpsc_serial_mul and the top level.
`default_nettype none

package bpsc_pkg;

   // field and register widths
   localparam int TIME_W      = 32;
   localparam int ADC_W       = 24;
   localparam int COEF_W      = 16;
   localparam int PRES_W      = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // shared bit-serial multiplier: signed multiplicand, unsigned multiplier
   localparam int MUL_MCAND_W  = 36;
   localparam int MUL_MPLIER_W = 24;
   localparam int MUL_PROD_W   = MUL_MCAND_W + MUL_MPLIER_W;
   localparam int MUL_CNT_W    = $clog2(MUL_MPLIER_W);

   localparam logic [COEF_W-1:0] WAIT_MS_RESET = 16'd20;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_SENS      = 3'd0,
      CSR_COEF_OFFSET    = 3'd1,
      CSR_COEF_SENS_TC   = 3'd2,
      CSR_COEF_OFFSET_TC = 3'd3,
      CSR_COEF_TREF      = 3'd4,
      CSR_COEF_TEMPSENS  = 3'd5,
      CSR_WAIT_MS        = 3'd6
   } csr_idx_type;

   // conversion start codes on the result
   typedef enum logic [1:0] {
      START_NONE  = 2'd0,
      START_PRESS = 2'd1,
      START_TEMP  = 2'd2
   } start_code_type;

   // sequencer phase
   typedef enum logic [1:0] {
      PH_START      = 2'd0,
      PH_PRESS_WAIT = 2'd1,
      PH_TEMP_WAIT  = 2'd2
   } phase_type;

   // compensation controller
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DT,
      ST_GO_OFF,
      ST_MUL_OFF,
      ST_SUM_OFF,
      ST_GO_SENS,
      ST_MUL_SENS,
      ST_SUM_SENS,
      ST_GO_P,
      ST_MUL_P,
      ST_SUM_P,
      ST_SUB_P,
      ST_DONE
   } ctl_state_type;

   // request to the multiplier
   typedef struct packed {
      logic                    start;
      logic [MUL_MCAND_W-1:0]  mcand;
      logic [MUL_MPLIER_W-1:0] mplier;
   } mul_req_type;

endpackage : bpsc_pkg

`default_nettype wire

// ===== rtl/bpsc_serial_mul.sv =====
// Radix-2 shift-add multiplier: one multiplier bit per cycle, signed x unsigned.
// Depends on bpsc_pkg (widths, mul_req_type).
`default_nettype none

module bpsc_serial_mul (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bpsc_pkg::mul_req_type             req,
   output logic                                   done,
   output logic [bpsc_pkg::MUL_PROD_W-1:0]        product
);
   import bpsc_pkg::*;

   localparam logic [MUL_CNT_W-1:0] LAST_STEP = MUL_CNT_W'(MUL_MPLIER_W - 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [MUL_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [MUL_MCAND_W-1:0]   m_ff, m_in;
   logic [MUL_MCAND_W:0]     hi_ff, hi_in;   // one guard bit over the multiplicand
   logic [MUL_MPLIER_W-1:0]  q_ff, q_in;
   logic [MUL_MCAND_W:0]     sum;
   logic                     last;

   assign last = busy_ff & (cnt_ff == LAST_STEP);

   always_comb begin
      sum     = hi_ff + (q_ff[0] ? {m_ff[MUL_MCAND_W-1], m_ff} : '0);
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      m_in    = m_ff;
      hi_in   = hi_ff;
      q_in    = q_ff;
      done_in = 1'b0;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         m_in    = req.mcand;
         hi_in   = '0;
         q_in    = req.mplier;
      end else if (busy_ff) begin
         // add then shift the pair right by one (arithmetic)
         hi_in  = {sum[MUL_MCAND_W], sum[MUL_MCAND_W:1]};
         q_in   = {sum[0], q_ff[MUL_MPLIER_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff  <= m_in;
      hi_ff <= hi_in;
      q_ff  <= q_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff[MUL_MCAND_W-1:0], q_ff};

endmodule : bpsc_serial_mul

`default_nettype wire

// ===== rtl/baro_pressure_sequence_compensate_core.sv =====
// Barometer conversion sequencer with first-order pressure compensation (top level).
// Depends on bpsc_pkg and bpsc_serial_mul.
`default_nettype none

// Channel  | Ports                                              | Handshake
// ---------+----------------------------------------------------+----------------------
// request  | req_now_ms, req_adc_word                           | req_valid / req_stall
// response | rsp_start_conversion, rsp_read_taken,              | rsp_valid / rsp_stall
//          | rsp_pressure_valid, rsp_pressure                   |
// config   | csr_index, csr_wdata                               | csr_we, no wait
//
// An item that does not finish a temperature read has its result in the output
// register in the cycle after acceptance. The item that completes the sequence
// runs three 24-step passes through the shared bit-serial multiplier, with dT,
// sum and subtract states around them; its result is loaded once the output is free.
// Reset (synchronous): phase 0, start time and raw pressure zero, coefficients
// zero, wait 20 ms. No item is taken while compensation runs, nor while the
// output register is full and stalled.

module baro_pressure_sequence_compensate_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [bpsc_pkg::TIME_W-1:0]        req_now_ms,
   input  wire logic [bpsc_pkg::ADC_W-1:0]         req_adc_word,
   // response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [1:0]                              rsp_start_conversion,
   output logic                                    rsp_read_taken,
   output logic                                    rsp_pressure_valid,
   output logic signed [bpsc_pkg::PRES_W-1:0]      rsp_pressure,
   // configuration
   input  wire logic                               csr_we,
   input  wire logic [bpsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bpsc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bpsc_pkg::*;

   localparam int DT_W  = ADC_W + 1;          // D2 - C5*256
   localparam int OFF_W = 37;                 // C2*2^16 + C4*dT/128
   localparam int T_W   = 40;                 // D1*SENS / 2^21
   localparam int X_W   = T_W + 1;            // minus OFF

   // ---------------- configuration ----------------
   // calibration word 6 is accepted but not stored: the pressure path ignores it
   logic [COEF_W-1:0] c_sens_ff, c_offset_ff, c_sens_tc_ff, c_offset_tc_ff;
   logic [COEF_W-1:0] c_tref_ff, wait_ms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_sens_ff      <= '0;
         c_offset_ff    <= '0;
         c_sens_tc_ff   <= '0;
         c_offset_tc_ff <= '0;
         c_tref_ff      <= '0;
         wait_ms_ff     <= WAIT_MS_RESET;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_COEF_SENS:      c_sens_ff      <= csr_wdata;
            CSR_COEF_OFFSET:    c_offset_ff    <= csr_wdata;
            CSR_COEF_SENS_TC:   c_sens_tc_ff   <= csr_wdata;
            CSR_COEF_OFFSET_TC: c_offset_tc_ff <= csr_wdata;
            CSR_COEF_TREF:      c_tref_ff      <= csr_wdata;
            CSR_WAIT_MS:        wait_ms_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- sequencer ----------------
   ctl_state_type      state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [TIME_W-1:0]  start_time_ff, start_time_in;
   logic [ADC_W-1:0]   raw_p_ff, raw_p_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         start_ff, start_in;
   logic               taken_ff, taken_in;
   logic               pvalid_ff, pvalid_in;
   logic [PRES_W-1:0]  pres_ff, pres_in;

   logic               out_free;
   logic               accept;
   logic               waited;
   logic               launch;        // accepted item finishes the sequence
   logic               load_now;      // immediate result from the accepted item
   logic               load_done;     // compensated result ready
   logic [TIME_W-1:0]  elapsed;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign elapsed   = req_now_ms - start_time_ff;
   assign waited    = (elapsed >= {{(TIME_W-COEF_W){1'b0}}, wait_ms_ff});

   always_comb begin
      phase_in      = phase_ff;
      start_time_in = start_time_ff;
      raw_p_in      = raw_p_ff;
      start_in      = START_NONE;
      taken_in      = 1'b0;
      launch        = 1'b0;
      case (phase_ff)
         PH_PRESS_WAIT: begin
            if (waited) begin
               raw_p_in      = req_adc_word;
               taken_in      = 1'b1;
               start_in      = START_TEMP;
               start_time_in = req_now_ms;
               phase_in      = PH_TEMP_WAIT;
            end
         end
         PH_TEMP_WAIT: begin
            if (waited) begin
               launch   = 1'b1;
               phase_in = PH_START;
            end
         end
         default: begin
            // start of sequence, and the unused phase code behaves the same
            start_in      = START_PRESS;
            start_time_in = req_now_ms;
            phase_in      = PH_PRESS_WAIT;
         end
      endcase
   end

   assign load_now = accept && !launch;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         start_time_ff <= '0;
         raw_p_ff      <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         start_time_ff <= start_time_in;
         raw_p_ff      <= raw_p_in;
      end
   end

   // ---------------- compensation datapath ----------------
   mul_req_type              mul_req;
   logic                     mul_done;
   logic [MUL_PROD_W-1:0]    prod;

   logic [ADC_W-1:0]  d2_ff;
   logic [DT_W-1:0]   dt_ff, dt_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [MUL_MCAND_W-1:0] sens_ff, sens_in;
   logic [T_W-1:0]    t_ff, t_in;
   logic [X_W-1:0]    x_ff, x_in;
   logic [X_W-1:0]    q15;
   logic [PRES_W-1:0] pres_sat;

   logic [MUL_PROD_W-1:0] prod_sh7, prod_sh8, prod_sh21;
   logic [X_W-1:0]        x_sh15;
   logic corr7, corr8, corr21, corr15;

   logic ld_dt, ld_off, ld_sens, ld_t, ld_x;

   bpsc_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mul_req),
      .done    (mul_done),
      .product (prod)
   );

   // truncating division by 2^k: arithmetic shift, plus one for a negative
   // value with bits shifted out
   always_comb begin
      prod_sh7  = $signed(prod) >>> 7;
      prod_sh8  = $signed(prod) >>> 8;
      prod_sh21 = $signed(prod) >>> 21;
      x_sh15    = $signed(x_ff) >>> 15;
      corr7     = prod[MUL_PROD_W-1] & (|prod[6:0]);
      corr8     = prod[MUL_PROD_W-1] & (|prod[7:0]);
      corr21    = prod[MUL_PROD_W-1] & (|prod[20:0]);
      corr15    = x_ff[X_W-1] & (|x_ff[14:0]);

      dt_in   = {1'b0, d2_ff} - {1'b0, c_tref_ff, 8'b0};
      off_in  = {{(OFF_W-COEF_W-16){1'b0}}, c_offset_ff, 16'b0}
              + prod_sh7[OFF_W-1:0] + {{(OFF_W-1){1'b0}}, corr7};
      sens_in = {{(MUL_MCAND_W-COEF_W-15){1'b0}}, c_sens_ff, 15'b0}
              + prod_sh8[MUL_MCAND_W-1:0] + {{(MUL_MCAND_W-1){1'b0}}, corr8};
      t_in    = prod_sh21[T_W-1:0] + {{(T_W-1){1'b0}}, corr21};
      x_in    = {t_ff[T_W-1], t_ff} - {{(X_W-OFF_W){off_ff[OFF_W-1]}}, off_ff};

      q15 = x_sh15 + {{(X_W-1){1'b0}}, corr15};
      // saturate: the bits above the 32-bit range must all match the sign
      if (q15[X_W-1:PRES_W-1] == {(X_W-PRES_W+1){q15[X_W-1]}}) begin
         pres_sat = q15[PRES_W-1:0];
      end else if (q15[X_W-1]) begin
         pres_sat = {1'b1, {(PRES_W-1){1'b0}}};
      end else begin
         pres_sat = {1'b0, {(PRES_W-1){1'b1}}};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (accept && launch) state_in = ST_DT;
         ST_DT:       state_in = ST_GO_OFF;
         ST_GO_OFF:   state_in = ST_MUL_OFF;
         ST_MUL_OFF:  if (mul_done) state_in = ST_SUM_OFF;
         ST_SUM_OFF:  state_in = ST_GO_SENS;
         ST_GO_SENS:  state_in = ST_MUL_SENS;
         ST_MUL_SENS: if (mul_done) state_in = ST_SUM_SENS;
         ST_SUM_SENS: state_in = ST_GO_P;
         ST_GO_P:     state_in = ST_MUL_P;
         ST_MUL_P:    if (mul_done) state_in = ST_SUM_P;
         ST_SUM_P:    state_in = ST_SUB_P;
         ST_SUB_P:    state_in = ST_DONE;
         ST_DONE:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      mul_req.start  = 1'b0;
      mul_req.mcand  = {{(MUL_MCAND_W-DT_W){dt_ff[DT_W-1]}}, dt_ff};
      mul_req.mplier = {{(MUL_MPLIER_W-COEF_W){1'b0}}, c_offset_tc_ff};
      ld_dt     = 1'b0;
      ld_off    = 1'b0;
      ld_sens   = 1'b0;
      ld_t      = 1'b0;
      ld_x      = 1'b0;
      load_done = 1'b0;
      case (state_ff)
         ST_DT:       ld_dt = 1'b1;
         ST_GO_OFF:   mul_req.start = 1'b1;
         ST_SUM_OFF:  ld_off = 1'b1;
         ST_GO_SENS: begin
            mul_req.start  = 1'b1;
            mul_req.mplier = {{(MUL_MPLIER_W-COEF_W){1'b0}}, c_sens_tc_ff};
         end
         ST_SUM_SENS: ld_sens = 1'b1;
         ST_GO_P: begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = sens_ff;
            mul_req.mplier = raw_p_ff;
         end
         ST_SUM_P:    ld_t = 1'b1;
         ST_SUB_P:    ld_x = 1'b1;
         ST_DONE:     load_done = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         d2_ff <= req_adc_word;
      end
      if (ld_dt) begin
         dt_ff <= dt_in;
      end
      if (ld_off) begin
         off_ff <= off_in;
      end
      if (ld_sens) begin
         sens_ff <= sens_in;
      end
      if (ld_t) begin
         t_ff <= t_in;
      end
      if (ld_x) begin
         x_ff <= x_in;
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_now || load_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load_done) begin
         pvalid_in = 1'b1;
         pres_in   = pres_sat;
      end else begin
         pvalid_in = 1'b0;
         pres_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_now) begin
         start_ff  <= start_in;
         taken_ff  <= taken_in;
         pvalid_ff <= pvalid_in;
         pres_ff   <= pres_in;
      end else if (load_done) begin
         start_ff  <= START_NONE;
         taken_ff  <= 1'b1;
         pvalid_ff <= pvalid_in;
         pres_ff   <= pres_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_start_conversion = start_ff;
   assign rsp_read_taken       = taken_ff;
   assign rsp_pressure_valid   = pvalid_ff;
   assign rsp_pressure         = $signed(pres_ff);

endmodule : baro_pressure_sequence_compensate_core

`default_nettype wire
